// ===== rtl/csrmv_pkg.sv =====
// csrmv_pkg: shared types and constants for the csr sparse matrix-vector block
// no dependencies; imported by the channel interfaces and all rtl modules
`timescale 1ns / 1ps

package csrmv_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2
  } op_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd1;

  // field widths
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned ROW_W    = 24;
  localparam int unsigned ROWNUM_W = 25;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // what a word in the pipeline asks of the accumulator
  typedef struct packed {
    logic acc;   // add the product into the row sum
    logic emit;  // close the row and emit its sum
  } stage_ctrl_t;

  // one finished row
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [ROWNUM_W-1:0]     number;
    logic                    last;
    logic                    sat;
  } row_result_t;

endpackage

// ===== rtl/csrmv_channels.sv =====
// csrmv channel interfaces: input item channel and row result channel
// depends on csrmv_pkg for field widths
`timescale 1ns / 1ps

interface csrmv_in_if
  import csrmv_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  logic                      row_end;

  modport source (output valid, operation, index, value, row_end, input ready);
  modport sink   (input valid, operation, index, value, row_end, output ready);
endinterface

interface csrmv_out_if
  import csrmv_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] row_sum;
  logic [ROWNUM_W-1:0]     row_number;
  logic                    last_row;
  logic                    saturated;

  modport source (output valid, row_sum, row_number, last_row, saturated, input ready);
  modport sink   (input valid, row_sum, row_number, last_row, saturated, output ready);
endinterface

// ===== rtl/csrmv_vstore.sv =====
// csrmv_vstore: dense vector store, one write port and one registered read port
// depends on csrmv_pkg for the element width
`timescale 1ns / 1ps

module csrmv_vstore
  import csrmv_pkg::*;
#(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/csrmv_mac.sv =====
// csrmv_mac: product register, saturating row accumulator and row counter
// depends on csrmv_pkg for stage control and row result types
`timescale 1ns / 1ps

module csrmv_mac
  import csrmv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  stage_ctrl_t               ctrl,
  input  logic signed [VALUE_W-1:0] mat_value,
  input  logic signed [VALUE_W-1:0] vec_value,
  input  logic [ROW_W-1:0]          first_row,
  input  logic [ROW_W-1:0]          row_count,
  output logic                      emit,
  output row_result_t               result
);

  stage_ctrl_t             ctrl_p;
  logic signed [SUM_W-1:0] product;
  logic signed [SUM_W-1:0] row_acc;
  logic                    row_clipped;
  logic [ROW_W-1:0]        row_counter;

  logic signed [SUM_W-1:0] sum_raw;
  logic                    ovf;
  logic signed [SUM_W-1:0] acc_next;
  logic                    clipped_next;
  logic [ROWNUM_W-1:0]     count_inc;
  logic                    last;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_p <= '0;
    end else if (adv) begin
      ctrl_p <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      product <= SUM_W'(mat_value) * SUM_W'(vec_value);
    end
  end

  // saturating add of the product
  always_comb begin
    sum_raw      = row_acc + product;
    ovf          = (row_acc[SUM_W-1] == product[SUM_W-1]) &&
                   (sum_raw[SUM_W-1] != row_acc[SUM_W-1]);
    acc_next     = row_acc;
    clipped_next = row_clipped;
    if (ctrl_p.acc) begin
      if (ovf) begin
        acc_next     = row_acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
        clipped_next = 1'b1;
      end else begin
        acc_next = sum_raw;
      end
    end
  end

  // row number and end-of-band flag
  assign count_inc = {1'b0, row_counter} + ROWNUM_W'(1);
  assign last      = (count_inc == {1'b0, row_count});

  assign emit          = adv && ctrl_p.emit;
  assign result.sum    = acc_next;
  assign result.number = {1'b0, first_row} + {1'b0, row_counter};
  assign result.last   = last;
  assign result.sat    = clipped_next;

  // accumulator and row counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc     <= '0;
      row_clipped <= 1'b0;
      row_counter <= '0;
    end else if (adv) begin
      if (ctrl_p.emit) begin
        row_acc     <= '0;
        row_clipped <= 1'b0;
        row_counter <= last ? '0 : count_inc[ROW_W-1:0];
      end else begin
        row_acc     <= acc_next;
        row_clipped <= clipped_next;
      end
    end
  end

endmodule

// ===== rtl/csr_sparse_matrix_vector_multiply.sv =====
// csr_sparse_matrix_vector_multiply: top level of the csr sparse matrix-vector block
// depends on csrmv_pkg, csrmv_channels, csrmv_vstore and csrmv_mac
`timescale 1ns / 1ps

// Streams one band of a CSR matrix against a dense vector held in an on-chip
// vector store of VECTOR_DEPTH 32-bit Q16.16 entries. Write words load the
// store, nonzero words multiply their value by the addressed vector entry and
// add the exact Q32.32 product into a saturating 64-bit row sum, and a nonzero
// with row_end set or an empty-row word emits the row with its absolute number
// (first_row plus rows emitted so far), a last-row flag and a clip flag.
// One word is taken every cycle while no finished row waits; a row result
// passes the read stage and multiply stage registers before it reaches the
// output register, and the pipeline stalls only while a finished row waits to
// be taken. The rate is set by the single vector store port (one write or one
// read per word) and the combinational saturating add.
// Vector entries that were never written read back as undefined data.
module csr_sparse_matrix_vector_multiply
  import csrmv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  csrmv_in_if.sink              item,
  csrmv_out_if.source           result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic [ROW_W-1:0]          first_row;
  logic [ROW_W-1:0]          row_count;
  logic                      adv;
  logic                      accept;
  logic [31:0]               idx_ext;
  logic                      in_range;
  logic [ADDR_W-1:0]         addr;
  logic                      mem_we;
  logic signed [VALUE_W-1:0] rdata;

  stage_ctrl_t               ctrl_r;
  logic                      in_range_r;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] vec_value;
  stage_ctrl_t               ctrl_in;

  logic                      emit;
  row_result_t               row_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_row <= '0;
      row_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_ROW: first_row <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished row is stuck
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;
  assign accept     = item.valid && adv;

  // address decode
  assign idx_ext  = {{(32-INDEX_W){1'b0}}, item.index};
  assign in_range = (idx_ext < 32'(VECTOR_DEPTH));
  assign addr     = idx_ext[ADDR_W-1:0];
  assign mem_we   = accept && (item.operation == OP_WRITE) && in_range;

  always_comb begin
    ctrl_in = '0;
    if (accept) begin
      unique case (item.operation)
        OP_NONZERO: begin
          ctrl_in.acc  = 1'b1;
          ctrl_in.emit = item.row_end;
        end
        OP_EMPTY: ctrl_in.emit = 1'b1;
        default: ;
      endcase
    end
  end

  csrmv_vstore #(
    .DEPTH  (VECTOR_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_vstore (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (item.value),
    .re    (adv),
    .raddr (addr),
    .rdata (rdata)
  );

  // read stage, lined up with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_r <= '0;
    end else if (adv) begin
      ctrl_r <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_range_r <= in_range;
      value_r    <= item.value;
    end
  end

  // columns beyond the store read as zero
  assign vec_value = in_range_r ? rdata : '0;

  csrmv_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctrl      (ctrl_r),
    .mat_value (value_r),
    .vec_value (vec_value),
    .first_row (first_row),
    .row_count (row_count),
    .emit      (emit),
    .result    (row_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.row_sum    <= row_res.sum;
      result.row_number <= row_res.number;
      result.last_row   <= row_res.last;
      result.saturated  <= row_res.sat;
    end
  end

endmodule

// ===== rtl/csrmv_checker.sv =====
// csrmv_checker: port-level assertions for the csr sparse matrix-vector block
// depends on csrmv_pkg; bound to csr_sparse_matrix_vector_multiply below
`timescale 1ns / 1ps

module csrmv_checker
  import csrmv_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SUM_W-1:0] out_sum,
  input logic [ROWNUM_W-1:0]     out_number,
  input logic                    out_last,
  input logic                    cfg_we,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [ROW_W-1:0] row_count_seen;

  // mirror of the band size register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count_seen <= '0;
    end else if (cfg_we && (cfg_index == REG_ROW_COUNT)) begin
      row_count_seen <= cfg_data;
    end
  end

  // a stalled row holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_number))
    else $error("row result changed while stalled");

  // reset leaves no row pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("row result valid after reset");

  // input backpressure only comes from a waiting row
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting row");

  // end of band needs a nonzero band size
  a_last_needs_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> row_count_seen != '0)
    else $error("last row flagged with an empty band");

endmodule

bind csr_sparse_matrix_vector_multiply csrmv_checker u_csrmv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (item.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_sum    (result.row_sum),
  .out_number (result.row_number),
  .out_last   (result.last_row),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);

// ===== sim/tb_csr_sparse_matrix_vector_multiply.sv =====
// tb_csr_sparse_matrix_vector_multiply: self-checking testbench for the csr spmv block
// predicts row sums in a band model and checks every row word against it
// depends on csrmv_pkg, csrmv_channels and csr_sparse_matrix_vector_multiply
`timescale 1ns / 1ps

module tb_csr_sparse_matrix_vector_multiply;
  import csrmv_pkg::*;

  localparam int unsigned VEC_DEPTH      = 4096;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned ITEMS_PER_RAND = 175;
  localparam logic [1:0]  OP_RESERVED    = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csrmv_in_if  item_ch ();
  csrmv_out_if row_ch ();

  csr_sparse_matrix_vector_multiply #(
    .VECTOR_DEPTH(VEC_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (row_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // band model state
  logic signed [VALUE_W-1:0] vec_mem [VEC_DEPTH];
  bit                        vec_written [VEC_DEPTH];
  logic [INDEX_W-1:0]        written_cols [$];
  logic signed [SUM_W-1:0]   acc_sum;
  logic                      acc_clipped;
  logic [ROW_W-1:0]          row_idx;
  logic [ROW_W-1:0]          band_first;
  logic [ROW_W-1:0]          band_count;
  row_result_t               pending_rows [$];

  // traffic shaping knobs and counters
  int          send_idle_pct;
  int          recv_stall_pct;
  int          send_burst;
  int          recv_burst;
  int unsigned words_sent;
  int unsigned reserved_sent;
  int unsigned rows_checked;
  int unsigned sat_rows;
  int unsigned last_rows;
  int unsigned mismatches;

  // close the current row: queue its expected word and clear the sum
  task automatic close_row();
    row_result_t       row;
    logic [ROW_W:0]    next_idx;
    logic              is_last;
    next_idx = {1'b0, row_idx} + 1'b1;
    is_last  = (next_idx == {1'b0, band_count});
    row.sum    = acc_sum;
    row.number = {1'b0, band_first} + {1'b0, row_idx};
    row.last   = is_last;
    row.sat    = acc_clipped;
    pending_rows.push_back(row);
    row_idx     = is_last ? '0 : next_idx[ROW_W-1:0];
    acc_sum     = '0;
    acc_clipped = 1'b0;
  endtask

  // exact q32.32 product into the saturating row sum
  task automatic add_product(input logic signed [VALUE_W-1:0] mat_val,
                             input logic signed [VALUE_W-1:0] vec_val);
    logic signed [SUM_W-1:0] wide_a;
    logic signed [SUM_W-1:0] wide_b;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] total;
    wide_a = mat_val;
    wide_b = vec_val;
    prod   = wide_a * wide_b;
    total  = acc_sum + prod;
    if (acc_sum[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc_sum[SUM_W-1]) begin
      total       = acc_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
      acc_clipped = 1'b1;
    end
    acc_sum = total;
  endtask

  // advance the band model by one accepted word
  task automatic spmv_step(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val, input logic rend);
    case (op)
      OP_WRITE: begin
        vec_mem[idx] = val;
        if (!vec_written[idx]) begin
          vec_written[idx] = 1'b1;
          written_cols.push_back(idx);
        end
      end
      OP_NONZERO: begin
        add_product(val, vec_mem[idx]);
        if (rend) close_row();
      end
      OP_EMPTY: close_row();
      default: ;
    endcase
  endtask

  // send one word; called and returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val, input logic rend);
    if (send_burst > 0) begin
      send_burst--;
    end else if ($urandom_range(99) < 4) begin
      send_burst = $urandom_range(10, 40);
    end else begin
      while ($urandom_range(99) < send_idle_pct) begin
        item_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.index     <= idx;
    item_ch.value     <= val;
    item_ch.row_end   <= rend;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    spmv_step(op, idx, val, rend);
    if (op == OP_RESERVED) reserved_sent++;
    else words_sent++;
    @(negedge clk);
  endtask

  // drop valid, wait for every expected row, then let the pipeline empty
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write both band registers, block idle
  task automatic set_band(input logic [ROW_W-1:0] first, input logic [ROW_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIRST_ROW;
    cfg_data  <= first;
    @(negedge clk);
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= count;
    @(negedge clk);
    cfg_we     <= 1'b0;
    band_first  = first;
    band_count  = count;
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($signed($urandom_range(16)) - 8) <<< 16;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] rand_address();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return INDEX_W'($urandom_range(VEC_DEPTH - 1));
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_column();
    return written_cols[$urandom_range(written_cols.size() - 1)];
  endfunction

  // a row of random nonzeros; some rows are cut short by an empty-row word
  task automatic send_random_row();
    int   nnz;
    bit   cut_short;
    nnz       = $urandom_range(5);
    cut_short = ($urandom_range(9) == 0);
    if (nnz == 0) begin
      send_item(OP_EMPTY, INDEX_W'($urandom), $urandom, 1'($urandom));
    end else begin
      for (int j = 0; j < nnz; j++) begin
        if ($urandom_range(9) == 0)
          send_item(OP_WRITE, rand_address(), rand_value(), 1'($urandom));
        send_item(OP_NONZERO, pick_column(), rand_value(),
                  (j == nnz - 1) && !cut_short);
      end
      if (cut_short) send_item(OP_EMPTY, INDEX_W'($urandom), $urandom, 1'($urandom));
    end
  endtask

  // a row of extreme products on one column, mostly ends clipped
  task automatic send_heavy_row();
    logic [INDEX_W-1:0]        col;
    logic signed [VALUE_W-1:0] mat_val;
    int                        nnz;
    col     = rand_address();
    mat_val = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    nnz     = $urandom_range(2, 5);
    send_item(OP_WRITE, col, $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
              1'($urandom));
    for (int j = 0; j < nnz; j++)
      send_item(OP_NONZERO, col, mat_val, j == nnz - 1);
  endtask

  // mix of vector loads, rows, heavy rows and reserved-op noise
  task automatic run_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned sel;
    start = words_sent;
    while (words_sent - start < count) begin
      sel = $urandom_range(99);
      if (sel < 15 || written_cols.size() == 0)
        send_item(OP_WRITE, rand_address(), rand_value(), 1'($urandom));
      else if (sel < 20)
        send_item(OP_RESERVED, INDEX_W'($urandom), $urandom, 1'($urandom));
      else if (sel < 25)
        send_heavy_row();
      else
        send_random_row();
    end
    wait_drained();
  endtask

  // directed: extremes, every operation, clipping both ways, cut-short row
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_band(24'd0, 24'd3);
    send_item(OP_WRITE, 12'd0, 32'sh7FFF_FFFF, 1'b1);
    send_item(OP_WRITE, 12'hFFF, 32'sh8000_0000, 1'b0);
    send_item(OP_WRITE, 12'hAAA, 32'sh0001_0000, 1'b0);
    send_item(OP_WRITE, 12'h555, 32'shFFFF_0000, 1'b0);
    send_item(OP_NONZERO, 12'hAAA, 32'sh0003_0000, 1'b1);
    send_item(OP_EMPTY, 12'h000, 32'sh0, 1'b0);
    send_item(OP_RESERVED, 12'h555, $urandom, 1'b1);
    // positive clip, then a small negative add stays clipped
    send_item(OP_NONZERO, 12'd0, 32'sh7FFF_FFFF, 1'b0);
    send_item(OP_NONZERO, 12'hFFF, 32'sh8000_0000, 1'b0);
    send_item(OP_NONZERO, 12'hFFF, 32'sh8000_0000, 1'b0);
    send_item(OP_NONZERO, 12'h555, 32'sh0001_0000, 1'b1);
    // negative clip
    send_item(OP_NONZERO, 12'd0, 32'sh8000_0000, 1'b0);
    send_item(OP_NONZERO, 12'd0, 32'sh8000_0000, 1'b0);
    send_item(OP_NONZERO, 12'd0, 32'sh8000_0000, 1'b1);
    // empty-row word closes a row with a pending sum
    send_item(OP_NONZERO, 12'hAAA, 32'sh0000_0005, 1'b0);
    send_item(OP_EMPTY, 12'hFFF, 32'shFFFF_FFFF, 1'b1);
    send_item(OP_NONZERO, 12'h555, 32'sh0, 1'b1);
    wait_drained();
  endtask

  // top of the row-number range, every row the last of its band
  task automatic test_band_edges();
    set_band(24'hFF_FFFF, 24'd1);
    send_item(OP_NONZERO, 12'hAAA, 32'shFFFF_FFFF, 1'b1);
    send_item(OP_EMPTY, 12'h000, 32'sh0, 1'b0);
    send_item(OP_WRITE, 12'h555, 32'sh1234_5678, 1'b1);
    send_item(OP_NONZERO, 12'h555, 32'sh0000_0002, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_band(ROW_W'($urandom), ROW_W'($urandom_range(2, 9)));
    run_random_traffic(ITEMS_PER_RAND);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 59;
    recv_stall_pct = 0;
    set_band(24'd0, 24'hFF_FFFF);
    run_random_traffic(ITEMS_PER_RAND);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    set_band(24'hFF_FFFF, 24'd0);
    run_random_traffic(ITEMS_PER_RAND);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    // count just past the current row so the band wraps a few times
    set_band(ROW_W'($urandom), ROW_W'(row_idx + $urandom_range(2, 6)));
    run_random_traffic(ITEMS_PER_RAND);
  endtask

  // receiver ready pattern
  always @(negedge clk) begin
    if (recv_burst > 0) begin
      recv_burst--;
      row_ch.ready <= 1'b1;
    end else if ($urandom_range(99) < 4) begin
      recv_burst = $urandom_range(10, 40);
      row_ch.ready <= 1'b1;
    end else begin
      row_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each row word with the oldest expectation
  always @(posedge clk) begin
    row_result_t got;
    row_result_t want;
    if (!rst && row_ch.valid && row_ch.ready) begin
      got.sum    = row_ch.row_sum;
      got.number = row_ch.row_number;
      got.last   = row_ch.last_row;
      got.sat    = row_ch.saturated;
      if (pending_rows.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected row word: sum %h row %0d last %b sat %b",
                   got.sum, got.number, got.last, got.sat);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (want.sat) sat_rows++;
        if (want.last) last_rows++;
        if (got !== want) begin
          if (mismatches < 10)
            $display("row mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                     want.sum, want.number, want.last, want.sat,
                     got.sum, got.number, got.last, got.sat);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (row_ch.valid && row_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_FIRST_ROW;
    cfg_data          = '0;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_WRITE;
    item_ch.index     = '0;
    item_ch.value     = '0;
    item_ch.row_end   = 1'b0;
    row_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    send_burst        = 0;
    recv_burst        = 0;
    words_sent        = 0;
    reserved_sent     = 0;
    rows_checked      = 0;
    sat_rows          = 0;
    last_rows         = 0;
    mismatches        = 0;
    acc_sum           = '0;
    acc_clipped       = 1'b0;
    row_idx           = '0;
    band_first        = '0;
    band_count        = '0;
    foreach (vec_written[i]) vec_written[i] = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_band_edges();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    wait_drained();
    $display("ran %0d words plus %0d reserved-op words over six band settings",
             words_sent, reserved_sent);
    $display("checked %0d rows: %0d clipped, %0d closing a band, %0d mismatches",
             rows_checked, sat_rows, last_rows, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
